@@ src/ksd_pkg.sv @@
// ksd_pkg: shared types, constants and the generator step for the keyed
// stream descrambler
// no dependencies
package ksd_pkg;

  // stream phase
  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_e;

  // result status codes
  localparam logic [1:0] STATUS_DATA     = 2'd0;
  localparam logic [1:0] STATUS_MATCH    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  // configuration register indexes (word address bit 2)
  localparam logic REG_METHOD = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [2:0]  METHOD_MAX     = 3'd4;
  localparam logic [31:0] LENGTH_RESET   = 32'd1;
  localparam logic [31:0] KEY_LAST_POS   = 32'd3;
  localparam logic [31:0] CHECK_LAST_POS = 32'd3;

  // one generator step result
  typedef struct packed {
    logic [31:0] seed;
    logic [15:0] value;
  } gen_res_t;

  // seed mask per method
  function automatic logic [31:0] mask_of(input logic [2:0] m);
    logic [31:0] r;
    unique case (m)
      3'd1:    r = 32'h91B2_A2D1;
      3'd2:    r = 32'h4A7C_1B87;
      3'd3:    r = 32'hF939_41E6;
      3'd4:    r = 32'hFD09_5E94;
      default: r = 32'h4C35_8938;
    endcase
    return r;
  endfunction

  // low-half add constant per method
  function automatic logic [15:0] padd_of(input logic [2:0] m);
    logic [15:0] r;
    unique case (m)
      3'd1:    r = 16'h7D14;
      3'd2:    r = 16'h1A82;
      3'd3:    r = 16'h02BB;
      3'd4:    r = 16'hE09C;
      default: r = 16'h62E9;
    endcase
    return r;
  endfunction

  // high-half add constant per method
  function automatic logic [15:0] qadd_of(input logic [2:0] m);
    logic [15:0] r;
    unique case (m)
      3'd1:    r = 16'hA26B;
      3'd2:    r = 16'hF03C;
      3'd3:    r = 16'h7B12;
      3'd4:    r = 16'h4E8F;
      default: r = 16'h3619;
    endcase
    return r;
  endfunction

  // one generator step: new seed and the unmasking value
  function automatic gen_res_t gen_step(input logic [31:0] s, input logic [2:0] m);
    gen_res_t    res;
    logic        cneg;
    logic        dneg;
    logic [15:0] bx;
    logic [15:0] cx;
    cneg = s[31];
    dneg = s[23];
    bx = cneg ? 16'hFFFF : {s[22:8], 1'b0};
    cx = dneg ? 16'hFFFF : {s[6:0], 9'b0};
    cx = cx + s[15:0] + padd_of(m);
    bx = bx + s[31:16] + qadd_of(m) + (cneg ? 16'hFFFF : 16'h0000)
       + (dneg ? 16'hFFFF : 16'h0000);
    res.seed  = {bx, 16'h0000} + {{16{cx[15]}}, cx};
    res.value = bx;
    return res;
  endfunction

endpackage

@@ src/keyed_stream_descrambler_top.sv @@
// keyed_stream_descrambler_top: descrambler datapath, phase control, apb
// registers and a two-entry output buffer
// depends on ksd_pkg
//
// Takes one raw byte per transfer: four key bytes, payload_length data bytes,
// then four checksum bytes. Each data byte gives one decoded byte (status 0);
// the last checksum byte gives a verdict (status 1 match, 2 mismatch, byte 0).
// Key and the first three checksum bytes give no result. Every byte is
// handled by the generator step and checksum update that sit between the
// state registers and the output register, so one byte per cycle is
// sustained while in_ready_o is high; each result is registered. A
// two-entry output buffer keeps in_ready_o high while one result waits, so
// the input stalls only when two results are held. Write registers only
// while the block is idle; method writes above 4 are ignored.
module keyed_stream_descrambler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic [7:0]  byte_in_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  // result output
  output logic [7:0]  byte_out_o,
  output logic [1:0]  status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } res_t;

  // configuration registers
  logic [2:0]  method_q;
  logic [31:0] length_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= 3'd0;
      length_q <= ksd_pkg::LENGTH_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ksd_pkg::REG_METHOD) begin
        if (pwdata[31:0] <= {29'd0, ksd_pkg::METHOD_MAX}) begin
          method_q <= pwdata[2:0];
        end
      end else begin
        length_q <= pwdata;
      end
    end
  end

  // register read
  always_comb begin
    if (paddr[2] == ksd_pkg::REG_LENGTH) begin
      prdata = length_q;
    end else begin
      prdata = {29'd0, method_q};
    end
  end

  // stream state
  ksd_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] seed_q, seed_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  pad_q, pad_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] shift_q, shift_d;
  logic [23:0] hold_q, hold_d;

  logic              in_xfer;
  logic              res_valid;
  res_t              res;
  ksd_pkg::gen_res_t gen;
  logic [7:0]        dec;
  logic [15:0]       chk1;
  logic [15:0]       chk2;
  logic [32:0]       pos_inc;

  assign in_xfer = in_valid_i & in_ready_o;
  assign gen     = ksd_pkg::gen_step(seed_q, method_q);
  assign pos_inc = {1'b0, pos_q} + 33'd1;
  assign chk1    = hold_q[23:8] ^ gen.value;
  assign chk2    = {hold_q[7:0], byte_in_i} - gen.value;
  assign dec     = toggle_q ? (byte_in_i - pad_q) : (byte_in_i ^ gen.value[7:0]);

  // per-byte step
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    seed_d    = seed_q;
    toggle_d  = toggle_q;
    pad_d     = pad_q;
    sum_d     = sum_q;
    shift_d   = shift_q;
    hold_d    = hold_q;
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_q)
      ksd_pkg::PH_DATA: begin
        if (!toggle_q) begin
          seed_d = gen.seed;
          pad_d  = gen.value[7:0];
        end
        toggle_d = ~toggle_q;
        sum_d    = sum_q + {8'd0, dec};
        shift_d  = {shift_q[11:0], 4'd0} + {{12{shift_q[15]}}, shift_q[15:12]}
                 + {8'd0, dec};
        pos_d    = pos_inc[31:0];
        if (pos_inc >= {1'b0, length_q}) begin
          phase_d = ksd_pkg::PH_CHECK;
          pos_d   = '0;
        end
        res_valid  = 1'b1;
        res.data   = dec;
        res.status = ksd_pkg::STATUS_DATA;
      end
      ksd_pkg::PH_CHECK: begin
        if (pos_q < ksd_pkg::CHECK_LAST_POS) begin
          hold_d = {hold_q[15:0], byte_in_i};
          pos_d  = pos_inc[31:0];
        end else begin
          seed_d     = gen.seed;
          phase_d    = ksd_pkg::PH_KEY;
          pos_d      = '0;
          hold_d     = '0;
          res_valid  = 1'b1;
          res.data   = 8'd0;
          res.status = (chk1 == sum_q && chk2 == shift_q) ? ksd_pkg::STATUS_MATCH
                                                         : ksd_pkg::STATUS_MISMATCH;
        end
      end
      default: begin
        // key phase, also the unused phase code
        phase_d = ksd_pkg::PH_KEY;
        seed_d  = {seed_q[23:0], byte_in_i};
        pos_d   = pos_inc[31:0];
        if (pos_q >= ksd_pkg::KEY_LAST_POS) begin
          seed_d   = {seed_q[23:0], byte_in_i} ^ ksd_pkg::mask_of(method_q);
          toggle_d = 1'b0;
          pad_d    = '0;
          sum_d    = '0;
          shift_d  = '0;
          hold_d   = '0;
          pos_d    = '0;
          phase_d  = (length_q == 32'd0) ? ksd_pkg::PH_CHECK : ksd_pkg::PH_DATA;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ksd_pkg::PH_KEY;
      pos_q    <= '0;
      seed_q   <= '0;
      toggle_q <= 1'b0;
      pad_q    <= '0;
      sum_q    <= '0;
      shift_q  <= '0;
      hold_q   <= '0;
    end else if (in_xfer) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      seed_q   <= seed_d;
      toggle_q <= toggle_d;
      pad_q    <= pad_d;
      sum_q    <= sum_d;
      shift_q  <= shift_d;
      hold_q   <= hold_d;
    end
  end

  // output register plus skid entry
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_xfer;
  logic new_res;

  assign in_ready_o = ~skid_valid_q;
  assign out_xfer   = out_valid_q & out_ready_i;
  assign new_res    = in_xfer & res_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_xfer) begin
      out_valid_d = new_res;
      out_d       = res;
    end else if (new_res) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = out_q.data;
  assign status_o    = out_q.status;

endmodule
